>>> hw/rtl/iwgv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwgv_pkg
// Shared types and constants for the IMU window gesture vote block.
// ----------------------------------------------------------------------------
package iwgv_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hAA;

    // Truncating divide by 100 for |yaw| <= 32768: (x * 5243) >> 19.
    localparam int          RECIP_SHIFT = 19;
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          DEG_MAG_W   = 9;     // |yaw| / 100 <= 327

    // Configuration port
    localparam int              CFG_ADDR_W    = 8;
    localparam int              CFG_DATA_W    = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_UP   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_DOWN = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_YAW_RIGHT  = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_YAW_LEFT   = 8'd3;

    localparam logic [14:0] PITCH_UP_RST   = 15'd2900;
    localparam logic [14:0] PITCH_DOWN_RST = 15'd3000;
    localparam logic [15:0] YAW_RIGHT_RST  = 16'd2000;
    localparam logic [15:0] YAW_LEFT_RST   = 16'd2500;

    // Vote queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [1:0] {
        GEST_DOWN  = 2'd0,
        GEST_UP    = 2'd1,
        GEST_LEFT  = 2'd2,
        GEST_RIGHT = 2'd3
    } gesture_t;

    // One classified sample: which thresholds it crossed
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } votes_t;

endpackage

>>> hw/rtl/iwgv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwgv_front
// Accepts frames, drops bad headers, latches the yaw offset from the first
// good frame and classifies each good frame into threshold votes.
// ----------------------------------------------------------------------------
module iwgv_front
    import iwgv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,
    output logic                  push,
    output votes_t                push_votes,
    input  logic                  queue_full
);

    logic [14:0] pitch_up_thr_reg;
    logic [14:0] pitch_down_thr_reg;
    logic [15:0] yaw_right_thr_reg;
    logic [15:0] yaw_left_thr_reg;

    logic               stg_valid_reg, stg_valid_next;
    logic signed [15:0] stg_yaw_reg;
    logic signed [15:0] stg_pitch_reg;
    logic signed [9:0]  stg_deg_reg;
    logic signed [15:0] off100_reg, off100_next;
    logic               first_pending_reg, first_pending_next;

    logic               accept;
    logic               hdr_ok;
    logic signed [15:0] yaw_in;
    logic [16:0]        yaw_ext;
    logic [16:0]        yaw_mag;
    logic [29:0]        yaw_prod;
    logic [9:0]         deg_mag;
    logic signed [9:0]  deg_in;
    logic signed [15:0] deg16;
    logic signed [15:0] deg100;
    logic signed [17:0] rel_yaw;
    logic signed [16:0] pitch17;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_up_thr_reg   <= PITCH_UP_RST;
            pitch_down_thr_reg <= PITCH_DOWN_RST;
            yaw_right_thr_reg  <= YAW_RIGHT_RST;
            yaw_left_thr_reg   <= YAW_LEFT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_PITCH_UP:   pitch_up_thr_reg   <= cfg_wdata[14:0];
                CFG_PITCH_DOWN: pitch_down_thr_reg <= cfg_wdata[14:0];
                CFG_YAW_RIGHT:  yaw_right_thr_reg  <= cfg_wdata;
                CFG_YAW_LEFT:   yaw_left_thr_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- input decode ----------------
    assign hdr_ok = (s_tdata[7:0] == HDR_BYTE) && (s_tdata[15:8] == HDR_BYTE);
    assign yaw_in = $signed(s_tdata[31:16]);

    // whole degrees, truncated toward zero
    assign yaw_ext  = {yaw_in[15], yaw_in};
    assign yaw_mag  = yaw_in[15] ? (~yaw_ext + 17'd1) : yaw_ext;
    assign yaw_prod = 30'(yaw_mag) * 30'(RECIP_100);
    assign deg_mag  = {1'b0, yaw_prod[RECIP_SHIFT +: DEG_MAG_W]};
    assign deg_in   = yaw_in[15] ? $signed(10'd0 - deg_mag) : $signed(deg_mag);

    assign s_tready = !stg_valid_reg || !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = stg_valid_reg && !queue_full;

    // ---------------- classify ----------------
    assign deg16  = {{6{stg_deg_reg[9]}}, stg_deg_reg};
    assign deg100 = (deg16 <<< 6) + (deg16 <<< 5) + (deg16 <<< 2);

    assign rel_yaw = {{2{stg_yaw_reg[15]}}, stg_yaw_reg}
                   - {{2{off100_reg[15]}}, off100_reg};
    assign pitch17 = {stg_pitch_reg[15], stg_pitch_reg};

    always_comb begin
        push_votes.up    = pitch17 < $signed(17'd0 - {2'b00, pitch_up_thr_reg});
        push_votes.down  = pitch17 > $signed({2'b00, pitch_down_thr_reg});
        push_votes.right = rel_yaw > $signed({2'b00, yaw_right_thr_reg});
        push_votes.left  = rel_yaw < $signed(18'd0 - {2'b00, yaw_left_thr_reg});
    end

    always_comb begin
        stg_valid_next     = stg_valid_reg;
        off100_next        = off100_reg;
        first_pending_next = first_pending_reg;
        if (accept) begin
            stg_valid_next = hdr_ok;
        end else if (push) begin
            stg_valid_next = 1'b0;
        end
        // the first good frame sees a zero offset, then sets it
        if (push && first_pending_reg) begin
            off100_next        = deg100;
            first_pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg     <= 1'b0;
            off100_reg        <= '0;
            first_pending_reg <= 1'b1;
        end else begin
            stg_valid_reg     <= stg_valid_next;
            off100_reg        <= off100_next;
            first_pending_reg <= first_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_yaw_reg   <= yaw_in;
            stg_pitch_reg <= $signed(s_tdata[47:32]);
            stg_deg_reg   <= deg_in;
        end
    end

endmodule

>>> hw/rtl/iwgv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwgv_queue
// Short FIFO of classified votes between the front and back parts.
// ----------------------------------------------------------------------------
module iwgv_queue
    import iwgv_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  votes_t push_votes,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output votes_t pop_votes
);

    votes_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_votes = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_votes;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("vote queue count overflow");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("vote queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && full) |-> pop)
        else $error("vote queue pushed while full");

endmodule

>>> hw/rtl/iwgv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwgv_back
// Counts votes over a window, evaluates on the frame after a full window
// and holds the resulting gesture in the output register.
// ----------------------------------------------------------------------------
module iwgv_back
    import iwgv_pkg::*;
#(
    parameter int WINDOW_SAMPLES = 20
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    input  votes_t   q_votes,
    output logic     pop,
    output logic     m_tvalid,
    input  logic     m_tready,
    output gesture_t m_gesture
);

    localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);
    localparam int HALF  = WINDOW_SAMPLES / 2;

    typedef enum logic [1:0] {
        PREV_NONE,
        PREV_DOWN,
        PREV_UP
    } prev_t;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] up_reg, up_next;
    logic [CNT_W-1:0] down_reg, down_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] right_reg, right_next;
    prev_t            prev_reg, prev_next, prev_eval;
    logic             out_valid_reg, out_valid_next;
    gesture_t         gest_reg, gest_next, gest_eval;
    logic             emit;
    logic             window_full;

    assign pop         = q_valid && (!out_valid_reg || m_tready);
    assign window_full = (cnt_reg == CNT_W'(WINDOW_SAMPLES));
    assign m_tvalid    = out_valid_reg;
    assign m_gesture   = gest_reg;

    // priority: down, up, left, right; down/up do not repeat
    always_comb begin
        emit      = 1'b0;
        gest_eval = GEST_DOWN;
        prev_eval = PREV_NONE;
        if (down_reg >= CNT_W'(HALF)) begin
            emit      = (prev_reg != PREV_DOWN);
            gest_eval = GEST_DOWN;
            prev_eval = PREV_DOWN;
        end else if (up_reg >= CNT_W'(HALF)) begin
            emit      = (prev_reg != PREV_UP);
            gest_eval = GEST_UP;
            prev_eval = PREV_UP;
        end else if (left_reg >= CNT_W'(HALF)) begin
            emit      = 1'b1;
            gest_eval = GEST_LEFT;
        end else if (right_reg >= CNT_W'(HALF)) begin
            emit      = 1'b1;
            gest_eval = GEST_RIGHT;
        end
    end

    always_comb begin
        cnt_next       = cnt_reg;
        up_next        = up_reg;
        down_next      = down_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && !m_tready;
        gest_next      = gest_reg;
        if (pop) begin
            if (window_full) begin
                // this item only triggers evaluation; its sample is dropped
                cnt_next   = '0;
                up_next    = '0;
                down_next  = '0;
                left_next  = '0;
                right_next = '0;
                prev_next  = prev_eval;
                if (emit) begin
                    out_valid_next = 1'b1;
                    gest_next      = gest_eval;
                end
            end else begin
                cnt_next   = cnt_reg + CNT_W'(1);
                up_next    = up_reg + CNT_W'(q_votes.up);
                down_next  = down_reg + CNT_W'(q_votes.down);
                left_next  = left_reg + CNT_W'(q_votes.left);
                right_next = right_reg + CNT_W'(q_votes.right);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            up_reg        <= '0;
            down_reg      <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            prev_reg      <= PREV_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            up_reg        <= up_next;
            down_reg      <= down_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gest_reg <= gest_next;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(WINDOW_SAMPLES))
        else $error("sample count beyond window");

    a_votes_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        up_reg <= cnt_reg && down_reg <= cnt_reg &&
        left_reg <= cnt_reg && right_reg <= cnt_reg)
        else $error("vote count exceeds sample count");

    a_clear_after_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && window_full) |=> (cnt_reg == '0 && up_reg == '0 && down_reg == '0))
        else $error("counters not cleared after evaluation");

    a_no_emit_below_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg || m_tready) && !(pop && window_full) |=> !out_valid_reg)
        else $error("gesture emitted without evaluation");

endmodule

>>> hw/rtl/imu_window_gesture_vote_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_window_gesture_vote_top
// IMU frame gesture detector: windowed threshold votes on yaw and pitch.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one IMU frame per item (header, yaw, pitch bytes).
//   Frames without the AA AA header are dropped in the front stage.
//   m_ channel carries one gesture code per item when a window ends with
//   a decision (0 down, 1 up, 2 left, 3 right).
//   cfg_we/cfg_addr/cfg_wdata write the four thresholds; write only while
//   no frame is in flight.
// Timing:
//   One frame per cycle sustained while no held result stalls the vote
//   counter. A frame is registered in the classify stage, then passes the
//   four-entry vote queue; the gesture it triggers is registered onto m_tvalid.
// Reset (aresetn low, synchronous): thresholds to defaults, counters and
//   queue cleared, yaw offset waits for the next good frame.
// Stall: a held result stalls the vote counter; the queue absorbs four
//   frames and the classify stage one more, then s_tready drops.
// ----------------------------------------------------------------------------
module imu_window_gesture_vote_top
    import iwgv_pkg::*;
#(
    parameter int WINDOW_SAMPLES = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // header_first, header_second, yaw_low, yaw_high, pitch_low, pitch_high
    input  logic [47:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // gesture [1:0], zero fill [7:2]
    output logic [7:0]            m_tdata
);

    logic     push;
    votes_t   push_votes;
    logic     queue_full;
    logic     pop;
    logic     q_valid;
    votes_t   q_votes;
    gesture_t gesture;

    iwgv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_votes (push_votes),
        .queue_full (queue_full)
    );

    iwgv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_votes (push_votes),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (q_valid),
        .pop_votes  (q_votes)
    );

    iwgv_back #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_votes   (q_votes),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_gesture (gesture)
    );

    assign m_tdata = {6'b0, gesture};

endmodule
